// ===== hdl/lrt_pkg.sv =====
`default_nettype none

package lrt_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // HOLD keeps every cell, PUSH moves cells up to the position one place back,
    // PULL moves cells from the position onwards one place forward.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_PULL
    } t_cell_op_e;

endpackage

`default_nettype wire

// ===== hdl/lrt_cell.sv =====
`default_nettype none

module lrt_cell #(
    parameter int KEY_BITS = 16,
    parameter int IDX_BITS = 4,
    parameter int INDEX    = 0
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  lrt_pkg::t_cell_op_e     i_op,
    input  wire  [IDX_BITS-1:0]     i_pos,
    input  wire  [KEY_BITS-1:0]     i_cmp_key,
    input  wire  [KEY_BITS-1:0]     i_left_key,
    input  wire                     i_left_valid,
    input  wire  [KEY_BITS-1:0]     i_right_key,
    input  wire                     i_right_valid,
    output logic [KEY_BITS-1:0]     o_key,
    output logic                    o_valid,
    output logic                    o_match
);

    logic [KEY_BITS-1:0] r_key;
    logic                r_valid;
    logic                at_or_before;
    logic                at_or_after;

    assign at_or_before = (IDX_BITS'(INDEX) <= i_pos);
    assign at_or_after  = (IDX_BITS'(INDEX) >= i_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_op)
                lrt_pkg::CELL_PUSH: begin
                    if (at_or_before) begin
                        r_key   <= i_left_key;
                        r_valid <= i_left_valid;
                    end
                end
                lrt_pkg::CELL_PULL: begin
                    if (at_or_after) begin
                        r_key   <= i_right_key;
                        r_valid <= i_right_valid;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_key == i_cmp_key);

endmodule

`default_nettype wire

// ===== hdl/lrt_ctrl.sv =====
`default_nettype none

module lrt_ctrl #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16,
    parameter int IDX_BITS = 4,
    parameter int CNT_BITS = 5
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [lrt_pkg::CMD_W-1:0]           i_cmd,
    input  wire  [KEY_BITS-1:0]                 i_key,
    input  wire  [CAPACITY-1:0]                 i_match,
    input  wire  [CAPACITY-1:0]                 i_valid,
    input  wire  [CAPACITY-1:0][KEY_BITS-1:0]   i_keys,
    output lrt_pkg::t_cell_op_e                 o_cell_op,
    output logic [IDX_BITS-1:0]                 o_pos,
    output logic [KEY_BITS-1:0]                 o_push_key,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [lrt_pkg::STATUS_W-1:0]        o_status,
    output logic [KEY_BITS-1:0]                 o_victim_key,
    output logic [CNT_BITS-1:0]                 o_count
);

    typedef enum logic {
        ST_IDLE,
        ST_UPD
    } t_state;

    t_state                        r_state;
    logic [lrt_pkg::CMD_W-1:0]     r_cmd;
    logic [KEY_BITS-1:0]           r_key;
    logic                          r_hit;
    logic [IDX_BITS-1:0]           r_pos;
    logic [KEY_BITS-1:0]           r_victim;
    logic [CNT_BITS-1:0]           r_count;
    logic                          r_out_valid;
    logic [lrt_pkg::STATUS_W-1:0]  r_status;
    logic [KEY_BITS-1:0]           r_out_key;
    logic [CNT_BITS-1:0]           r_out_count;

    logic                          hit_c;
    logic [IDX_BITS-1:0]           pos_c;
    logic [CAPACITY-1:0]           tail_c;
    logic [KEY_BITS-1:0]           victim_c;

    lrt_pkg::t_cell_op_e           n_op;
    logic [IDX_BITS-1:0]           n_pos;
    logic [lrt_pkg::STATUS_W-1:0]  n_status;
    logic [KEY_BITS-1:0]           n_victim;
    logic [CNT_BITS-1:0]           n_count;

    logic                          out_free;
    logic                          upd_fire;
    logic                          is_full;
    logic                          is_empty;
    logic [CNT_BITS-1:0]           count_dec;

    // The occupied cells form one unbroken run from cell 0, so the oldest
    // entry is the valid cell whose right-hand neighbour is empty.
    always_comb begin
        hit_c    = |i_match;
        pos_c    = '0;
        tail_c   = i_valid & ~{1'b0, i_valid[CAPACITY-1:1]};
        victim_c = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_match[i]) begin
                pos_c = pos_c | IDX_BITS'(i);
            end
            if (tail_c[i]) begin
                victim_c = victim_c | i_keys[i];
            end
        end
    end

    assign is_full   = (r_count == CNT_BITS'(CAPACITY));
    assign is_empty  = (r_count == '0);
    assign count_dec = r_count - CNT_BITS'(1);

    always_comb begin
        n_op     = lrt_pkg::CELL_HOLD;
        n_pos    = r_pos;
        n_status = lrt_pkg::STATUS_OK;
        n_victim = '0;
        n_count  = r_count;
        case (r_cmd)
            lrt_pkg::CMD_INSERT: begin
                if (r_hit) begin
                    n_op = lrt_pkg::CELL_PUSH;
                end else if (is_full) begin
                    n_status = lrt_pkg::STATUS_FULL;
                end else begin
                    n_op    = lrt_pkg::CELL_PUSH;
                    n_pos   = r_count[IDX_BITS-1:0];
                    n_count = r_count + CNT_BITS'(1);
                end
            end
            lrt_pkg::CMD_VICTIM: begin
                if (is_empty) begin
                    n_status = lrt_pkg::STATUS_MISS;
                end else begin
                    n_op     = lrt_pkg::CELL_PULL;
                    n_pos    = count_dec[IDX_BITS-1:0];
                    n_victim = r_victim;
                    n_count  = count_dec;
                end
            end
            lrt_pkg::CMD_ERASE: begin
                if (r_hit) begin
                    n_op    = lrt_pkg::CELL_PULL;
                    n_count = count_dec;
                end else begin
                    n_status = lrt_pkg::STATUS_MISS;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign upd_fire = (r_state == ST_UPD) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd    <= i_cmd;
                        r_key    <= i_key;
                        r_hit    <= hit_c;
                        r_pos    <= pos_c;
                        r_victim <= victim_c;
                        r_state  <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (out_free) begin
                        r_count     <= n_count;
                        r_status    <= n_status;
                        r_out_key   <= n_victim;
                        r_out_count <= n_count;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_cell_op    = upd_fire ? n_op : lrt_pkg::CELL_HOLD;
    assign o_pos        = n_pos;
    assign o_push_key   = r_key;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_victim_key = r_out_key;
    assign o_count      = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(i_valid) == int'(r_count))
        else $error("occupied cells disagree with entry count");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_match))
        else $error("key held in more than one cell");

    a_update_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_UPD))
        else $error("accepted item did not enter the update cycle");

    a_cells_move_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell_op != lrt_pkg::CELL_HOLD) |=> o_out_valid)
        else $error("cells moved without a result being issued");

endmodule

`default_nettype wire

// ===== hdl/lru_replacement_tracker.sv =====
// Recency tracker for up to CAPACITY distinct keys, held in a row of cells
// with the most recent key in cell 0.
// Input channel s_axis: tuser carries the command (insert or touch, take
// victim, erase), tdata carries the key. Output channel m_axis: tuser carries
// the status, tdata carries the victim key and the entry count after the
// operation. Every accepted transfer yields exactly one result transfer.
// An item is handled in steps: on the accepting edge every cell compares its
// key with the incoming one and the hit position and oldest key are stored;
// in the update state, once the output register is free, the cells up to or
// from the position move one place (none on a full or miss status) and the
// result is loaded into the output register; input waits until then.
// The output register lets the next item be accepted while a result waits.
// When the receiver stalls with a result still pending, the update cycle
// holds and input stays blocked until the result is taken.
// Synchronous reset empties every cell and clears the entry count; no
// clearing pass is needed.
`default_nettype none

module lru_replacement_tracker #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: key.
    input  wire  [((KEY_BITS+7)/8)*8-1:0]         s_axis_tdata,
    // Fields from bit 0: command.
    input  wire  [lrt_pkg::CMD_W-1:0]            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // Fields from bit 0: victim_key, entry_count.
    output logic [((KEY_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata,
    // Fields from bit 0: status.
    output logic [lrt_pkg::STATUS_W-1:0]         m_axis_tuser
);

    localparam int IDX_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int M_DATA_W  = ((KEY_BITS + CNT_BITS + 7) / 8) * 8;

    logic [CAPACITY-1:0][KEY_BITS-1:0] cell_key;
    logic [CAPACITY-1:0]               cell_valid;
    logic [CAPACITY-1:0]               cell_match;
    lrt_pkg::t_cell_op_e               cell_op;
    logic [IDX_BITS-1:0]               cell_pos;
    logic [KEY_BITS-1:0]               push_key;
    logic [KEY_BITS-1:0]               in_key;
    logic [KEY_BITS-1:0]               victim_key;
    logic [CNT_BITS-1:0]               entry_count;

    assign in_key = s_axis_tdata[KEY_BITS-1:0];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [KEY_BITS-1:0] left_key;
            logic                left_valid;
            logic [KEY_BITS-1:0] right_key;
            logic                right_valid;

            if (g == 0) begin : g_first
                assign left_key   = push_key;
                assign left_valid = 1'b1;
            end else begin : g_inner_left
                assign left_key   = cell_key[g-1];
                assign left_valid = cell_valid[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign right_key   = '0;
                assign right_valid = 1'b0;
            end else begin : g_inner_right
                assign right_key   = cell_key[g+1];
                assign right_valid = cell_valid[g+1];
            end

            lrt_cell #(
                .KEY_BITS (KEY_BITS),
                .IDX_BITS (IDX_BITS),
                .INDEX    (g)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_op          (cell_op),
                .i_pos         (cell_pos),
                .i_cmp_key     (in_key),
                .i_left_key    (left_key),
                .i_left_valid  (left_valid),
                .i_right_key   (right_key),
                .i_right_valid (right_valid),
                .o_key         (cell_key[g]),
                .o_valid       (cell_valid[g]),
                .o_match       (cell_match[g])
            );
        end
    endgenerate

    lrt_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .IDX_BITS (IDX_BITS),
        .CNT_BITS (CNT_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_key        (in_key),
        .i_match      (cell_match),
        .i_valid      (cell_valid),
        .i_keys       (cell_key),
        .o_cell_op    (cell_op),
        .o_pos        (cell_pos),
        .o_push_key   (push_key),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_status     (m_axis_tuser),
        .o_victim_key (victim_key),
        .o_count      (entry_count)
    );

    assign m_axis_tdata = M_DATA_W'({entry_count, victim_key});

endmodule

`default_nettype wire
